// File: rtl/wabt_pkg.sv
// ----------------------------------------------------------------------------
// wabt_pkg: shared types and constants
// Entry layout, operation and status codes, sequencer states and table sizing
// for the weekly alarm table bell timer.
// ----------------------------------------------------------------------------
package wabt_pkg;

    localparam int TABLE_DEPTH = 128;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

    localparam logic [2:0] MODE_TICK   = 3'd0;
    localparam logic [2:0] MODE_ADD    = 3'd1;
    localparam logic [2:0] MODE_UPDATE = 3'd2;
    localparam logic [2:0] MODE_DELETE = 3'd3;
    localparam logic [2:0] MODE_RING   = 3'd4;
    localparam logic [2:0] MODE_READ   = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_RANGE     = 2'd3;

    localparam logic [1:0] CFG_ACTIVE_GROUP  = 2'd0;
    localparam logic [1:0] CFG_CLOCK_PRESENT = 2'd1;

    typedef struct packed {
        logic [15:0] id;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [15:0] seconds;
        logic [2:0]  weekday;
        logic        enable;
        logic [1:0]  group;
    } t_entry;

    typedef struct packed {
        logic [2:0]  mode;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [2:0]  weekday;
        logic [15:0] secs;
        logic        enable;
        logic [1:0]  group;
        logic [15:0] tid;
        logic [6:0]  ridx;
    } t_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_HOLD
    } t_state;

endpackage

// File: rtl/wabt_if.sv
// ----------------------------------------------------------------------------
// wabt interfaces
// Operation input channel, result output channel and configuration write
// channel, each a valid/ready stream.
// ----------------------------------------------------------------------------
interface wabt_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [4:0]  now_hour;
    logic [5:0]  now_minute;
    logic [2:0]  weekday;
    logic [15:0] ring_seconds;
    logic        entry_enable;
    logic [1:0]  entry_group;
    logic [15:0] target_id;
    logic [6:0]  read_index;
    modport source (output valid, mode, now_hour, now_minute, weekday, ring_seconds,
                    entry_enable, entry_group, target_id, read_index, input ready);
    modport sink (input valid, mode, now_hour, now_minute, weekday, ring_seconds,
                  entry_enable, entry_group, target_id, read_index, output ready);
endinterface

interface wabt_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        bell_on;
    logic [15:0] result_id;
    logic [4:0]  out_hour;
    logic [5:0]  out_minute;
    logic [15:0] out_seconds;
    logic [2:0]  out_weekday;
    logic        out_enable;
    logic [1:0]  out_group;
    logic [7:0]  entry_count;
    modport source (output valid, status, bell_on, result_id, out_hour, out_minute,
                    out_seconds, out_weekday, out_enable, out_group, entry_count,
                    input ready);
    modport sink (input valid, status, bell_on, result_id, out_hour, out_minute,
                  out_seconds, out_weekday, out_enable, out_group, entry_count,
                  output ready);
endinterface

interface wabt_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/wabt_cell.sv
// ----------------------------------------------------------------------------
// wabt_cell: one alarm table slot
// Holds one entry and takes its neighbour's entry on every shift cycle.
// ----------------------------------------------------------------------------
module wabt_cell
    import wabt_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_shift,
    input  t_entry i_d,
    output t_entry o_q
);

    t_entry r_q;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

// File: rtl/wabt_ctrl.sv
// ----------------------------------------------------------------------------
// wabt_ctrl: sequencer and bell logic
// Rotates the cell chain once per item, acts on the entry at the head and
// finishes the bell, count and result registers at the end of the pass.
// ----------------------------------------------------------------------------
module wabt_ctrl
    import wabt_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    wabt_in_if.sink      i_in,
    wabt_out_if.source   o_out,
    wabt_cfg_if.sink     i_cfg,
    input  t_entry       i_head,
    input  t_entry       i_next,
    output logic         o_shift,
    output t_entry       o_tail
);

    t_state r_state, n_state;
    t_item  r_item;
    logic [IDX_W-1:0] r_idx;
    logic [CNT_W-1:0] r_used;
    logic [15:0] r_prev_id;
    logic        r_found;
    logic [15:0] r_hit_secs;
    logic        r_scan;
    logic [15:0] r_rid;
    t_entry      r_shown;
    logic        r_shown_ok;
    logic        r_ringing;
    logic [15:0] r_len;
    logic [15:0] r_elap;
    logic [5:0]  r_last_min;
    logic        r_min_valid;
    logic [1:0]  r_group;
    logic        r_clk_present;
    logic        r_out_valid;
    logic [1:0]  r_status;
    logic        r_bell;
    logic [15:0] r_res_id;
    t_entry      r_res_entry;
    logic [7:0]  r_count;

    logic w_accept, w_last, w_in_use, w_hit, w_load;
    logic [15:0] w_new_id;
    logic w_ring;
    logic [15:0] w_len, w_elap;
    logic [1:0]  w_status;
    logic [CNT_W-1:0] w_used;

    assign w_accept = i_in.valid && i_in.ready;
    assign w_last   = (r_idx == IDX_W'(TABLE_DEPTH - 1));
    assign w_in_use = (CNT_W'(r_idx) < r_used);
    assign w_new_id = (r_used == '0) ? 16'd1 : r_prev_id + 16'd1;
    assign w_load   = !r_out_valid || o_out.ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) n_state = S_RUN;
            S_RUN:  if (w_last) n_state = S_HOLD;
            S_HOLD: if (w_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        i_in.ready  = (r_state == S_IDLE);
        i_cfg.ready = 1'b1;
        o_shift     = (r_state == S_RUN);
    end

    // work on the entry at the head of the chain
    always_comb begin
        o_tail = i_head;
        w_hit  = 1'b0;
        unique case (r_item.mode)
            MODE_TICK: begin
                w_hit = r_scan && w_in_use && !r_found && i_head.enable &&
                        i_head.group == r_group && i_head.hour == r_item.hour &&
                        i_head.minute == r_item.minute &&
                        i_head.weekday == r_item.weekday;
            end
            MODE_ADD: begin
                if (CNT_W'(r_idx) == r_used) begin
                    o_tail = '{id: w_new_id, hour: r_item.hour, minute: r_item.minute,
                               seconds: r_item.secs, weekday: r_item.weekday,
                               enable: r_item.enable, group: r_item.group};
                end
            end
            MODE_UPDATE: begin
                w_hit = w_in_use && !r_found && i_head.id == r_item.tid;
                if (w_hit) begin
                    o_tail = '{id: i_head.id, hour: r_item.hour, minute: r_item.minute,
                               seconds: r_item.secs, weekday: r_item.weekday,
                               enable: r_item.enable, group: r_item.group};
                end
            end
            MODE_DELETE: begin
                w_hit = w_in_use && !r_found && i_head.id == r_item.tid;
                // from the hit on, every slot takes its successor
                if (w_hit || r_found) begin
                    o_tail = i_next;
                end
            end
            default: begin
            end
        endcase
    end

    // end of pass: status, count and bell
    always_comb begin
        w_status = ST_OK;
        w_used   = r_used;
        w_ring   = r_ringing;
        w_len    = r_len;
        w_elap   = r_elap;
        unique case (r_item.mode)
            MODE_ADD: begin
                if (r_used >= CNT_W'(TABLE_DEPTH)) w_status = ST_FULL;
                else w_used = r_used + CNT_W'(1);
            end
            MODE_UPDATE: begin
                if (!r_found) w_status = ST_NOT_FOUND;
            end
            MODE_DELETE: begin
                if (!r_found) w_status = ST_NOT_FOUND;
                else w_used = r_used - CNT_W'(1);
            end
            MODE_READ: begin
                if (!r_shown_ok) w_status = ST_RANGE;
            end
            default: begin
            end
        endcase
        if (!r_ringing && ((r_item.mode == MODE_TICK && r_found) ||
                           r_item.mode == MODE_RING)) begin
            w_ring = 1'b1;
            w_len  = (r_item.mode == MODE_RING) ? r_item.secs : r_hit_secs;
            w_elap = 16'd0;
        end
        if (w_ring && w_elap >= w_len) begin
            w_ring = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_used        <= '0;
            r_ringing     <= 1'b0;
            r_len         <= '0;
            r_elap        <= '0;
            r_last_min    <= '0;
            r_min_valid   <= 1'b0;
            r_group       <= 2'd1;
            r_clk_present <= 1'b0;
            r_out_valid   <= 1'b0;
            r_idx         <= '0;
            r_found       <= 1'b0;
            r_scan        <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == CFG_ACTIVE_GROUP) r_group <= i_cfg.data;
                if (i_cfg.index == CFG_CLOCK_PRESENT) r_clk_present <= i_cfg.data[0];
            end
            if (o_out.valid && o_out.ready && !(r_state == S_HOLD && w_load)) begin
                r_out_valid <= 1'b0;
            end

            if (w_accept) begin
                r_idx   <= '0;
                r_found <= 1'b0;
                r_scan  <= 1'b0;
                if (i_in.mode == MODE_TICK) begin
                    if (r_ringing && r_elap != 16'hFFFF) r_elap <= r_elap + 16'd1;
                    if (r_clk_present && (!r_min_valid || i_in.now_minute != r_last_min)) begin
                        r_scan      <= 1'b1;
                        r_last_min  <= i_in.now_minute;
                        r_min_valid <= 1'b1;
                    end
                end
            end

            if (r_state == S_RUN) begin
                r_idx <= r_idx + IDX_W'(1);
                if (w_hit) r_found <= 1'b1;
            end

            if (r_state == S_HOLD && w_load) begin
                r_out_valid <= 1'b1;
                r_used      <= w_used;
                r_ringing   <= w_ring;
                r_len       <= w_len;
                r_elap      <= w_elap;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item     <= '{mode: i_in.mode, hour: i_in.now_hour, minute: i_in.now_minute,
                            weekday: i_in.weekday, secs: i_in.ring_seconds,
                            enable: i_in.entry_enable, group: i_in.entry_group,
                            tid: i_in.target_id, ridx: i_in.read_index};
            r_rid      <= '0;
            r_shown    <= '0;
            r_shown_ok <= 1'b0;
        end
        if (r_state == S_RUN) begin
            r_prev_id <= i_head.id;
            if (w_hit && r_item.mode == MODE_TICK) r_hit_secs <= i_head.seconds;
            if (r_item.mode == MODE_ADD && CNT_W'(r_idx) == r_used) r_rid <= w_new_id;
            if (r_item.mode == MODE_READ && w_in_use &&
                CMP_W'(r_idx) == CMP_W'(r_item.ridx)) begin
                r_shown    <= i_head;
                r_shown_ok <= 1'b1;
                r_rid      <= i_head.id;
            end
        end
        if (r_state == S_HOLD && w_load) begin
            r_status    <= w_status;
            r_bell      <= w_ring;
            r_res_id    <= r_rid;
            r_res_entry <= r_shown;
            r_count     <= (32'(w_used) > 255) ? 8'hFF : 8'(w_used);
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_status;
    assign o_out.bell_on     = r_bell;
    assign o_out.result_id   = r_res_id;
    assign o_out.out_hour    = r_res_entry.hour;
    assign o_out.out_minute  = r_res_entry.minute;
    assign o_out.out_seconds = r_res_entry.seconds;
    assign o_out.out_weekday = r_res_entry.weekday;
    assign o_out.out_enable  = r_res_entry.enable;
    assign o_out.out_group   = r_res_entry.group;
    assign o_out.entry_count = r_count;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(TABLE_DEPTH)) else $error("entry count past table depth");
    a_used_stable_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |=> $stable(r_used)) else $error("count moved mid pass");
    a_hold_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HOLD && w_load) |=> r_out_valid) else $error("result not loaded");
    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && w_last) |=> (r_state == S_HOLD && r_idx == '0))
        else $error("pass did not close");

endmodule

// File: rtl/weekly_alarm_table_bell_timer_top.sv
// ----------------------------------------------------------------------------
// weekly_alarm_table_bell_timer_top: weekly alarm table with bell timer
// Chain of table cells rotated by the sequencer once for every operation.
// ----------------------------------------------------------------------------
// Every operation (tick, add, update, delete, ring now, read) takes one full
// rotation of the cell chain, framed by an accept state and a finish state.
// The entry at the head cell is examined each cycle of the rotation, and the
// finish waits while the output register still holds an unread beat. One
// result beat may wait in the output register while the next beat starts.
module weekly_alarm_table_bell_timer_top
    import wabt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    wabt_in_if.sink    i_in,
    wabt_out_if.source o_out,
    wabt_cfg_if.sink   i_cfg
);

    t_entry w_q [TABLE_DEPTH];
    t_entry w_tail;
    logic   w_shift;

    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
        wabt_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (w_shift),
            .i_d     ((k == TABLE_DEPTH - 1) ? w_tail : w_q[(k + 1) % TABLE_DEPTH]),
            .o_q     (w_q[k])
        );
    end

    wabt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cfg   (i_cfg),
        .i_head  (w_q[0]),
        .i_next  (w_q[1]),
        .o_shift (w_shift),
        .o_tail  (w_tail)
    );

endmodule
